// ===== design/gbi_pkg.sv =====
// gbi_pkg: shared types and constants of the grid bilinear interpolator.
// Used by gbi_axis, gbi_blend, the top level and the testbench; no dependencies.
package gbi_pkg;

  localparam int NUM_STAGES = 14;
  localparam int T_W        = 22;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_Y_ORIGIN   = 3'd1,
    CFG_INV_STEP_X = 3'd2,
    CFG_INV_STEP_Y = 3'd3,
    CFG_COLS_USED  = 3'd4,
    CFG_ROWS_USED  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } gbi_axis_en_t;

  typedef struct packed {
    logic s9;
    logic s10;
    logic s11;
    logic s12;
    logic s13;
    logic s14;
  } gbi_blend_en_t;

endpackage

// ===== design/gbi_ram.sv =====
// gbi_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/gbi_axis.sv =====
// gbi_axis: per-axis coordinate pipeline (stages 2..7): cell index and clipped
// local coordinate from a position. Depends on gbi_pkg.
module gbi_axis import gbi_pkg::*; #(
  parameter int MAX = 64,
  localparam int IW = (MAX > 2) ? $clog2(MAX) : 1
) (
  input  logic                  clk,
  input  gbi_axis_en_t          en,
  input  logic signed [31:0]    pos,
  input  logic signed [31:0]    origin,
  input  logic [31:0]           inv,
  input  logic [6:0]            used,
  output logic [IW-1:0]         idx,
  output logic signed [T_W-1:0] t,
  output logic                  clip
);

  localparam logic signed [50:0] LIM_P = 51'sd1048576;
  localparam logic signed [50:0] LIM_N = -51'sd1048576;

  logic              neg2, neg3, neg4;
  logic [32:0]       mag2;
  logic [47:0]       plo3;
  logic [48:0]       phi3;
  logic [64:0]       m4;
  logic signed [50:0] u5;
  logic [IW-1:0]     i6;
  logic signed [50:0] t6;

  logic signed [32:0] d;
  logic [65:0]       q;
  logic [49:0]       uq;
  logic [11:0]       used_e, used_c, hi;
  logic signed [34:0] iraw;
  logic [11:0]       i_sel;

  always_comb begin
    d = {pos[31], pos} - {origin[31], origin};
    q = neg4 ? ({1'b0, m4} + 66'd65535) : {1'b0, m4};
    uq = q[65:16];
    used_e = {5'd0, used};
    if (used_e < 12'd2) begin
      used_c = 12'd2;
    end else if (used_e > 12'(MAX)) begin
      used_c = 12'(MAX);
    end else begin
      used_c = used_e;
    end
    hi = used_c - 12'd2;
    iraw = 35'(u5 >>> 16);
    if (u5 < 0) begin
      i_sel = 12'd0;
    end else if (iraw > $signed({23'd0, hi})) begin
      i_sel = hi;
    end else begin
      i_sel = iraw[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      neg2 <= d[32];
      mag2 <= d[32] ? 33'(-d) : d;
    end
    if (en.s3) begin
      neg3 <= neg2;
      plo3 <= mag2[15:0] * inv;
      phi3 <= mag2[32:16] * inv;
    end
    if (en.s4) begin
      neg4 <= neg3;
      m4   <= {17'd0, plo3} + {phi3, 16'd0};
    end
    if (en.s5) begin
      u5   <= neg4 ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
    end
    if (en.s6) begin
      i6 <= IW'(i_sel);
      t6 <= u5 - $signed({23'd0, i_sel, 16'd0});
    end
    if (en.s7) begin
      idx <= i6;
      if (t6 > LIM_P) begin
        t    <= T_W'(LIM_P);
        clip <= 1'b1;
      end else if (t6 < LIM_N) begin
        t    <= T_W'(LIM_N);
        clip <= 1'b1;
      end else begin
        t    <= T_W'(t6);
        clip <= 1'b0;
      end
    end
  end

endmodule

// ===== design/gbi_blend.sv =====
// gbi_blend: bilinear blend of four corner samples (stages 9..14) with
// output saturation and the output register. Depends on gbi_pkg.
module gbi_blend import gbi_pkg::*; (
  input  logic                  clk,
  input  gbi_blend_en_t         en,
  input  logic signed [31:0]    f00,
  input  logic signed [31:0]    f01,
  input  logic signed [31:0]    f10,
  input  logic signed [31:0]    f11,
  input  logic signed [T_W-1:0] tx,
  input  logic signed [T_W-1:0] ty,
  input  logic                  clip,
  output logic signed [31:0]    value,
  output logic                  sat
);

  localparam logic signed [47:0] R_MAX = 48'sd2147483647;
  localparam logic signed [47:0] R_MIN = -48'sd2147483648;

  logic signed [32:0]    d0_9, d1_9;
  logic signed [31:0]    f00_9, f10_9, f00_10, f10_10;
  logic signed [T_W-1:0] ty9, ty10, ty11, ty12;
  logic signed [T_W-1:0] tx9;
  logic                  c9, c10, c11, c12, c13;
  logic signed [54:0]    pa10, pb10;
  logic signed [39:0]    a11, b11, a12, a13;
  logic signed [40:0]    e12;
  logic signed [62:0]    pr13;
  logic signed [47:0]    r;

  assign r = 48'(a13) + 48'(pr13 >>> 16);

  always_ff @(posedge clk) begin
    if (en.s9) begin
      d0_9  <= 33'(f01) - 33'(f00);
      d1_9  <= 33'(f11) - 33'(f10);
      f00_9 <= f00;
      f10_9 <= f10;
      tx9   <= tx;
      ty9   <= ty;
      c9    <= clip;
    end
    if (en.s10) begin
      pa10   <= d0_9 * tx9;
      pb10   <= d1_9 * tx9;
      f00_10 <= f00_9;
      f10_10 <= f10_9;
      ty10   <= ty9;
      c10    <= c9;
    end
    if (en.s11) begin
      a11  <= 40'(f00_10) + 40'(pa10 >>> 16);
      b11  <= 40'(f10_10) + 40'(pb10 >>> 16);
      ty11 <= ty10;
      c11  <= c10;
    end
    if (en.s12) begin
      e12  <= 41'(b11) - 41'(a11);
      a12  <= a11;
      ty12 <= ty11;
      c12  <= c11;
    end
    if (en.s13) begin
      pr13 <= e12 * ty12;
      a13  <= a12;
      c13  <= c12;
    end
    if (en.s14) begin
      if (r > R_MAX) begin
        value <= 32'sh7fffffff;
        sat   <= 1'b1;
      end else if (r < R_MIN) begin
        value <= 32'sh80000000;
        sat   <= 1'b1;
      end else begin
        value <= 32'(r);
        sat   <= c13;
      end
    end
  end

endmodule

// ===== design/grid_bilinear_interpolator.sv =====
// Grid bilinear interpolator: one item per clock cycle, sustained, in both
// directions while the output is not stalled. A transaction on the input
// channel either stores one sample or asks for the bilinear value at
// (x_pos, y_pos); only queries give a result. The grid sits in four RAM
// banks split by row and column parity, so the four corners of a cell are
// read at once; writes and reads meet the banks at the same pipeline stage,
// in transaction order. The grid is not cleared by reset. Depends on gbi_pkg,
// gbi_ram, gbi_axis and gbi_blend.
module grid_bilinear_interpolator import gbi_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [5:0]           col,
  input  logic [5:0]           row,
  input  logic signed [31:0]   sample,
  input  logic signed [31:0]   x_pos,
  input  logic signed [31:0]   y_pos,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   interp_value,
  output logic                 saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IXW  = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int IYW  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int HC   = (MAX_COLS + 1) / 2;
  localparam int HR   = (MAX_ROWS + 1) / 2;
  localparam int CHW  = (HC > 1) ? $clog2(HC) : 1;
  localparam int RHW  = (HR > 1) ? $clog2(HR) : 1;
  localparam int BAW  = CHW + RHW;
  localparam int BDEP = 2 ** BAW;

  logic signed [31:0] x_origin, y_origin;
  logic [31:0]        inv_step_x, inv_step_y;
  logic [6:0]         cols_used, rows_used;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin   <= '0;
      y_origin   <= '0;
      inv_step_x <= 32'd65536;
      inv_step_y <= 32'd65536;
      cols_used  <= 7'd64;
      rows_used  <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_X_ORIGIN:   x_origin   <= cfg_data;
        CFG_Y_ORIGIN:   y_origin   <= cfg_data;
        CFG_INV_STEP_X: inv_step_x <= cfg_data;
        CFG_INV_STEP_Y: inv_step_y <= cfg_data;
        CFG_COLS_USED:  cols_used  <= cfg_data[6:0];
        CFG_ROWS_USED:  rows_used  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic [NUM_STAGES:1]   v;
  logic [NUM_STAGES+1:1] en;

  always_comb begin
    en[NUM_STAGES+1] = out_ready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[NUM_STAGES];

  logic               cmd_p    [1:7];
  logic [5:0]         col_p    [1:7];
  logic [5:0]         row_p    [1:7];
  logic signed [31:0] sample_p [1:7];
  logic signed [31:0] x1, y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          if (k == 1) begin
            v[k] <= in_valid;
          end else if (k == 8) begin
            v[k] <= v[7] && (cmd_t'(cmd_p[7]) == CMD_QUERY);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cmd_p[1]    <= cmd;
      col_p[1]    <= col;
      row_p[1]    <= row;
      sample_p[1] <= sample;
      x1          <= x_pos;
      y1          <= y_pos;
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        cmd_p[k]    <= cmd_p[k-1];
        col_p[k]    <= col_p[k-1];
        row_p[k]    <= row_p[k-1];
        sample_p[k] <= sample_p[k-1];
      end
    end
  end

  gbi_axis_en_t ax_en;
  assign ax_en = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5], s6: en[6], s7: en[7]};

  logic [IXW-1:0]        ix7;
  logic [IYW-1:0]        jy7;
  logic signed [T_W-1:0] tx7, ty7;
  logic                  cx7, cy7;

  gbi_axis #(.MAX(MAX_COLS)) u_axis_x (
    .clk(clk), .en(ax_en), .pos(x1), .origin(x_origin), .inv(inv_step_x),
    .used(cols_used), .idx(ix7), .t(tx7), .clip(cx7)
  );

  gbi_axis #(.MAX(MAX_ROWS)) u_axis_y (
    .clk(clk), .en(ax_en), .pos(y1), .origin(y_origin), .inv(inv_step_y),
    .used(rows_used), .idx(jy7), .t(ty7), .clip(cy7)
  );

  // write port, stage 7
  logic           wr_ok, we;
  logic [IXW-1:0] wcol;
  logic [IYW-1:0] wrow;
  logic [BAW-1:0] waddr;
  logic [1:0]     wbank;

  always_comb begin
    wr_ok = ({6'd0, col_p[7]} < 12'(MAX_COLS)) && ({6'd0, row_p[7]} < 12'(MAX_ROWS));
    we    = en[8] && v[7] && (cmd_t'(cmd_p[7]) == CMD_WRITE) && wr_ok;
    wcol  = IXW'(col_p[7]);
    wrow  = IYW'(row_p[7]);
    waddr = {RHW'(wrow >> 1), CHW'(wcol >> 1)};
    wbank = {wrow[0], wcol[0]};
  end

  // read addresses: each parity bank takes whichever of i, i+1 (j, j+1) matches
  logic [IXW-1:0] csel [2];
  logic [IYW-1:0] rsel [2];
  logic [31:0]    rd   [4];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      csel[p] = (ix7[0] == p[0]) ? ix7 : IXW'(ix7 + 1'b1);
      rsel[p] = (jy7[0] == p[0]) ? jy7 : IYW'(jy7 + 1'b1);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    gbi_ram #(.WIDTH(32), .DEPTH(BDEP)) u_ram (
      .clk(clk),
      .we(we && (wbank == 2'(b))),
      .waddr(waddr),
      .wdata(sample_p[7]),
      .re(en[8]),
      .raddr({RHW'(rsel[b/2] >> 1), CHW'(csel[b%2] >> 1)}),
      .rdata(rd[b])
    );
  end

  logic                  ip8, jp8, c8;
  logic signed [T_W-1:0] tx8, ty8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      ip8 <= ix7[0];
      jp8 <= jy7[0];
      tx8 <= tx7;
      ty8 <= ty7;
      c8  <= cx7 || cy7;
    end
  end

  gbi_blend_en_t bl_en;
  assign bl_en = '{s9: en[9], s10: en[10], s11: en[11], s12: en[12], s13: en[13],
                   s14: en[14]};

  gbi_blend u_blend (
    .clk(clk),
    .en(bl_en),
    .f00(rd[{jp8, ip8}]),
    .f01(rd[{jp8, !ip8}]),
    .f10(rd[{!jp8, ip8}]),
    .f11(rd[{!jp8, !ip8}]),
    .tx(tx8),
    .ty(ty8),
    .clip(c8),
    .value(interp_value),
    .sat(saturated)
  );

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_clean_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (en[8] && v[7] && (cmd_t'(cmd_p[7]) == CMD_WRITE)) |=> !v[8])
    else $error("write transaction entered the read stage");

endmodule

// ===== tb/grid_bilinear_interpolator_tb.sv =====
// Self-checking testbench for grid_bilinear_interpolator: directed table, then random
// sample writes and queries under several register settings, checked against a predictor.
// Depends on gbi_pkg and the grid_bilinear_interpolator RTL.
module grid_bilinear_interpolator_tb;
  import gbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int LOCAL_LIM = 1 << 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 255;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } interp_res_t;

  typedef struct {
    cmd_t               op;
    int                 c;
    int                 r;
    logic signed [31:0] smp;
    logic signed [31:0] px;
    logic signed [31:0] py;
    bit                 typed;
    logic signed [31:0] value;
    logic               sat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = CMD_WRITE;
  logic [5:0] col = '0;
  logic [5:0] row = '0;
  logic signed [31:0] sample = '0;
  logic signed [31:0] x_pos = '0;
  logic signed [31:0] y_pos = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] interp_value;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  grid_bilinear_interpolator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] grid_mem [GRID_ROWS*GRID_COLS];
  bit [GRID_ROWS*GRID_COLS-1:0] grid_written = '0;
  longint org_x = 0, org_y = 0;
  bit [31:0] inv_x = 32'h0001_0000, inv_y = 32'h0001_0000;
  bit [6:0] used_c = 7'd64, used_r = 7'd64;

  interp_res_t interp_q[$];
  int errors = 0, n_items = 0, n_queries = 0, n_results = 0, n_sat = 0, n_cfg = 0;
  int cycles = 0;
  int snd_idle_pct = 14, rcv_idle_pct = 68;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic bit locate_axis(input longint pos, input longint origin, input bit [31:0] inv,
                                     input bit [6:0] used, output int idx, output longint t);
    longint d, u, i, hi;
    bit [63:0] mag, m;
    bit clip;
    d = pos - origin;
    mag = (d >= 0) ? d : -d;
    m = mag * {32'b0, inv};
    u = (d >= 0) ? longint'(m >> 16) : -longint'((m + 64'd65535) >> 16);
    hi = (used < 2) ? 0 : (used > 64) ? 62 : longint'(used) - 2;
    i = u >>> 16;
    if (i < 0) i = 0;
    if (i > hi) i = hi;
    t = u - i * 65536;
    clip = 1'b0;
    if (t > LOCAL_LIM) begin
      t = LOCAL_LIM;
      clip = 1'b1;
    end
    if (t < -LOCAL_LIM) begin
      t = -LOCAL_LIM;
      clip = 1'b1;
    end
    idx = int'(i);
    return clip;
  endfunction

  function automatic longint grid_at(input int r, input int c);
    return longint'(grid_mem[r*GRID_COLS + c]);
  endfunction

  function automatic interp_res_t blend_point(input logic signed [31:0] px,
                                              input logic signed [31:0] py);
    interp_res_t res;
    int i, j;
    longint tx, ty, a, b, v;
    bit s;
    s = locate_axis(px, org_x, inv_x, used_c, i, tx);
    s = locate_axis(py, org_y, inv_y, used_r, j, ty) | s;
    a = (grid_at(j, i) * 65536 + (grid_at(j, i+1) - grid_at(j, i)) * tx) >>> 16;
    b = (grid_at(j+1, i) * 65536 + (grid_at(j+1, i+1) - grid_at(j+1, i)) * tx) >>> 16;
    v = (a * 65536 + (b - a) * ty) >>> 16;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      s = 1'b1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      s = 1'b1;
    end
    res.value = v[31:0];
    res.sat = s;
    return res;
  endfunction

  function automatic logic signed [31:0] rand_sample();
    if ($urandom_range(99) < 80) return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    return $urandom;
  endfunction

  task automatic send_item(input cmd_t op, input int c, input int r, input logic signed [31:0] smp,
                           input logic signed [31:0] px, input logic signed [31:0] py);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    col <= c[5:0];
    row <= r[5:0];
    sample <= smp;
    x_pos <= px;
    y_pos <= py;
    if (op == CMD_WRITE) begin
      grid_mem[r*GRID_COLS + c] = smp;
      grid_written[r*GRID_COLS + c] = 1'b1;
    end
    n_items++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // loads any corner of the target cell that has never been written
  task automatic fill_corners(input logic signed [31:0] px, input logic signed [31:0] py);
    int i, j, k;
    longint tx, ty;
    bit s;
    s = locate_axis(px, org_x, inv_x, used_c, i, tx);
    s = locate_axis(py, org_y, inv_y, used_r, j, ty);
    for (k = 0; k < 4; k++)
      if (!grid_written[(j + k/2)*GRID_COLS + i + k%2])
        send_item(CMD_WRITE, i + k%2, j + k/2, rand_sample(), $urandom, $urandom);
  endtask

  task automatic send_query(input logic signed [31:0] px, input logic signed [31:0] py,
                            input bit typed, input logic signed [31:0] value, input logic sat);
    interp_res_t res;
    fill_corners(px, py);
    res = blend_point(px, py);
    if (typed) begin
      res.value = value;
      res.sat = sat;
    end
    interp_q.push_back(res);
    n_queries++;
    send_item(CMD_QUERY, $urandom_range(63), $urandom_range(63), $urandom, px, py);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_X_ORIGIN:   org_x = longint'($signed(data));
      CFG_Y_ORIGIN:   org_y = longint'($signed(data));
      CFG_INV_STEP_X: inv_x = data;
      CFG_INV_STEP_Y: inv_y = data;
      CFG_COLS_USED:  used_c = data[6:0];
      CFG_ROWS_USED:  used_r = data[6:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (interp_q.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] ix,
                            input logic [31:0] iy, input logic [31:0] nc, input logic [31:0] nr);
    wait_drained();
    write_reg(CFG_X_ORIGIN, ox);
    write_reg(CFG_Y_ORIGIN, oy);
    write_reg(CFG_INV_STEP_X, ix);
    write_reg(CFG_INV_STEP_Y, iy);
    write_reg(CFG_COLS_USED, nc);
    write_reg(CFG_ROWS_USED, nr);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    interp_res_t exp_res;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, interp_q.size());
      $display("grid_bilinear_interpolator_tb: done, errors");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (saturated) n_sat++;
      if (interp_q.size() == 0) begin
        report($sformatf("unexpected result %h", interp_value));
      end else begin
        exp_res = interp_q.pop_front();
        if (interp_value !== exp_res.value)
          report($sformatf("interp_value %h, expected %h", interp_value, exp_res.value));
        if (saturated !== exp_res.sat)
          report($sformatf("saturated %b, expected %b", saturated, exp_res.sat));
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off once requested
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      if (hold_left < 400) begin
        hold_left++;
        out_ready <= 1'b0;
      end else begin
        hold_done = 1'b1;
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [31:0] V100 = 32'sh0064_0000;

  stim_row_t dir_table[] = '{
    '{CMD_WRITE, 0, 0, V100, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 1, 0, V100, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 0, 1, V100, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 1, 1, V100, 0, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 0, 0, 1, V100, 0},
    '{CMD_QUERY, 0, 0, 0, SMIN, 0, 1, V100, 1},
    '{CMD_QUERY, 0, 0, 0, 0, SMIN, 1, V100, 1},
    '{CMD_QUERY, 0, 0, 0, SMAX, SMAX, 0, 0, 0},
    '{CMD_WRITE, 0, 0, SMAX, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 1, 0, SMAX, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 0, 1, SMAX, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 1, 1, SMAX, 0, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 0, 0, 1, SMAX, 0},
    '{CMD_WRITE, 1, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 1, 1, 0, 0, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, -32'sd131072, 0, 1, SMAX, 1},
    '{CMD_QUERY, 0, 0, 0, 32'sh0000_8000, 32'sh0000_8000, 0, 0, 0},
    '{CMD_WRITE, 0, 0, SMIN, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 0, 1, SMIN, 0, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, -32'sd131072, 0, 1, SMIN, 1},
    '{CMD_QUERY, 0, 0, 0, 0, 0, 1, SMIN, 0},
    '{CMD_WRITE, 63, 63, 32'sh1234_5678, 0, 0, 0, 0, 0},
    '{CMD_QUERY, 0, 0, 0, 32'sh003F_0000, 32'sh003F_0000, 0, 0, 0}
  };

  initial begin
    int ph, n;
    logic signed [31:0] px, py;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_config(32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'd64, 32'd64);

    foreach (dir_table[k]) begin
      if (dir_table[k].op == CMD_WRITE)
        send_item(CMD_WRITE, dir_table[k].c, dir_table[k].r, dir_table[k].smp, $urandom, $urandom);
      else
        send_query(dir_table[k].px, dir_table[k].py, dir_table[k].typed,
                   dir_table[k].value, dir_table[k].sat);
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(32'hFFFD_0000, 32'h0005_0000, 32'h0002_0000, 32'h0000_8000, 32'd8, 32'd5);
        1: set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'h0001_0000, 32'd2, 32'd2);
        2: set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'd127, 32'd0);
        3: set_config($urandom, $urandom, 32'd0, 32'h0001_2345, 32'd1, 32'd100);
        4: set_config(32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'd64, 32'd64);
        default: set_config($urandom, $urandom, $urandom_range(1, 1 << 20),
                            $urandom_range(1, 1 << 20), $urandom_range(2, 64),
                            $urandom_range(2, 64));
      endcase
      snd_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 68 : 0;
      rcv_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 14 : 0;
      if (ph == 4) hold_req = 1'b1;
      n = n_items + PHASE_ITEMS;
      while (n_items < n) begin
        if ($urandom_range(99) < 30) begin
          send_item(CMD_WRITE, $urandom_range(63), $urandom_range(63), rand_sample(),
                    $urandom, $urandom);
        end else begin
          if ($urandom_range(99) < 65) begin
            px = 32'(org_x + longint'($signed($urandom_range(0, 1 << 23)) - (1 << 20)));
            py = 32'(org_y + longint'($signed($urandom_range(0, 1 << 23)) - (1 << 20)));
          end else begin
            px = $urandom;
            py = $urandom;
          end
          send_query(px, py, 1'b0, '0, 1'b0);
        end
      end
      if (ph == 2) wait_drained();
    end

    wait_drained();
    repeat (NUM_STAGES + 10) @(posedge clk);
    $display("covered %0d transactions (%0d queries), %0d results, %0d saturated,",
             n_items, n_queries, n_results, n_sat);
    $display("  %0d register writes over 7 settings, in %0d cycles", n_cfg, cycles);
    if (errors == 0) begin
      $display("grid_bilinear_interpolator_tb: done, clean");
    end else begin
      $display("grid_bilinear_interpolator_tb: done, errors");
    end
    $finish;
  end
endmodule
